// ===== rtl/core/idle_aged_node_cache_macros.svh =====
// Assertion macros used by the checker file.
`ifndef IDLE_AGED_NODE_CACHE_MACROS_SVH
`define IDLE_AGED_NODE_CACHE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define IANC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define IANC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ianc_pkg.sv =====
package ianc_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDLE_BITS = 16;
    localparam int SLOT_W    = $clog2(ENTRIES);
    localparam int FILL_W    = $clog2(ENTRIES + 1);

    localparam logic [IDLE_BITS-1:0] IDLE_MAX = {IDLE_BITS{1'b1}};
    localparam logic [IDLE_BITS:0]   DIR_AGE  = (IDLE_BITS+1)'(1);
    localparam logic [IDLE_BITS:0]   FILE_AGE = (IDLE_BITS+1)'(10);

    typedef enum logic [1:0] {
        MODE_LOOKUP  = 2'd0,
        MODE_INSERT  = 2'd1,
        MODE_INV_VOL = 2'd2,
        MODE_INV_ALL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_RESP
    } st_t;

    typedef struct packed {
        logic [7:0]           volume;
        logic [31:0]          dev;
        logic [31:0]          inode;
        logic                 is_dir;
        logic [IDLE_BITS-1:0] idle;
    } payload_t;

    typedef struct packed {
        logic     valid;
        payload_t pay;
    } entry_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  volume;
        logic [31:0] dev;
        logic [31:0] inode;
        logic        is_dir;
        logic        vol_changed;
    } req_t;

    typedef struct packed {
        logic shift_en;
        logic clr_all;
    } cell_ctl_t;

endpackage

// ===== rtl/core/ianc_cell.sv =====
module ianc_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  ianc_pkg::cell_ctl_t ctl,
    input  logic                wr_en,
    input  ianc_pkg::entry_t    wr_data,
    input  ianc_pkg::entry_t    nbr,
    output ianc_pkg::entry_t    cur
);

    logic               valid_reg;
    ianc_pkg::payload_t pay_reg;

    // Valid bit: clear all, direct write, or take the neighbor's
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.clr_all) begin
            valid_reg <= 1'b0;
        end else if (wr_en) begin
            valid_reg <= wr_data.valid;
        end else if (ctl.shift_en) begin
            valid_reg <= nbr.valid;
        end
    end

    // Payload: direct write or take the neighbor's, no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pay_reg <= wr_data.pay;
        end else if (ctl.shift_en) begin
            pay_reg <= nbr.pay;
        end
    end

    assign cur.valid = valid_reg;
    assign cur.pay   = pay_reg;

endmodule

// ===== rtl/core/idle_aged_node_cache.sv =====
// Idle-aged node cache directory, fully associative, keyed by volume/dev/inode.
// Input channel s_*: one request per transfer, s_tuser carries the mode
// (lookup, insert, invalidate one volume, invalidate all).
// Result channel m_*: exactly one result per request, in order.
// The entries sit in a ring of cells that rotates one slot per cycle, while a
// request is scanned, past a single compare/age unit at the head; a lookup,
// insert or volume invalidate makes one full turn. After the input transfer
// such a request scans the ring, an insert then writes its slot in a place
// step, and a response step loads the output register; invalidate all goes
// straight to the response step. One request is in work at a time, so the
// next request is taken only once the last has left the response step.
// s_tready is high only while no request is in work.
// The result sits in an output register; if the receiver stalls, it holds
// there and the block may still take the next request and work on it.
// Reset (aresetn low, synchronous) empties the directory and the output.
module idle_aged_node_cache (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] volume, [39:8] dev, [71:40] inode, [72] is_dir, [73] vol_changed
    input  logic [79:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] hit, [6:1] slot, [7] evicted, [14:8] fill_level
    output logic [15:0] m_tdata
);

    localparam int N  = ianc_pkg::ENTRIES;
    localparam int SW = ianc_pkg::SLOT_W;
    localparam int FW = ianc_pkg::FILL_W;
    localparam int IB = ianc_pkg::IDLE_BITS;

    ianc_pkg::st_t  state_reg, state_next;
    ianc_pkg::req_t req_reg, req_next;
    logic [SW-1:0]  idx_reg, idx_next;
    logic [FW-1:0]  used_reg, used_next;
    logic           found_reg, found_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic           ev_reg, ev_next;
    logic           have_free_reg, have_free_next;
    logic [SW-1:0]  free_reg, free_next;
    logic [IB-1:0]  peak_age_reg, peak_age_next;
    logic [SW-1:0]  max_slot_reg, max_slot_next;
    logic [FW-1:0]  keep_reg, keep_next;
    logic           m_valid_reg, m_valid_next;
    logic [15:0]    m_data_reg, m_data_next;

    ianc_pkg::cell_ctl_t ctl;
    ianc_pkg::entry_t    cell_out [N];
    ianc_pkg::entry_t    proc;
    ianc_pkg::entry_t    new_entry;
    logic [N-1:0]        wr_en;

    logic          accept, last, place_en, resp_en;
    logic          in_range, match;
    logic [IB:0]   sum;
    logic [IB-1:0] aged;
    logic [SW-1:0] target;
    logic          append, evict;

    assign accept = s_tvalid && s_tready;
    assign last   = (idx_reg == SW'(N - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ianc_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == ianc_pkg::MODE_INV_ALL) ?
                                 ianc_pkg::ST_RESP : ianc_pkg::ST_SCAN;
                end
            end
            ianc_pkg::ST_SCAN: begin
                if (last) begin
                    state_next = (req_reg.mode == ianc_pkg::MODE_INSERT) ?
                                 ianc_pkg::ST_PLACE : ianc_pkg::ST_RESP;
                end
            end
            ianc_pkg::ST_PLACE: state_next = ianc_pkg::ST_RESP;
            ianc_pkg::ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ianc_pkg::ST_IDLE;
                end
            end
            default: state_next = ianc_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready     = (state_reg == ianc_pkg::ST_IDLE);
        ctl.shift_en = (state_reg == ianc_pkg::ST_SCAN);
        ctl.clr_all  = (state_reg == ianc_pkg::ST_IDLE) && s_tvalid &&
                       (s_tuser == ianc_pkg::MODE_INV_ALL);
        place_en     = (state_reg == ianc_pkg::ST_PLACE);
        resp_en      = (state_reg == ianc_pkg::ST_RESP) && (!m_valid_reg || m_tready);
    end

    // Ring of cells, head at cell 0, processed head re-enters at the tail
    for (genvar k = 0; k < N; k++) begin : g_cell
        ianc_pkg::entry_t nbr;
        if (k == N - 1) begin : g_tail
            assign nbr = proc;
        end else begin : g_mid
            assign nbr = cell_out[k+1];
        end
        assign wr_en[k] = place_en && (target == SW'(k));
        ianc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .wr_en   (wr_en[k]),
            .wr_data (new_entry),
            .nbr     (nbr),
            .cur     (cell_out[k])
        );
    end

    // Entry written by an insert
    always_comb begin
        new_entry.valid      = 1'b1;
        new_entry.pay.volume = req_reg.volume;
        new_entry.pay.dev    = req_reg.dev;
        new_entry.pay.inode  = req_reg.inode;
        new_entry.pay.is_dir = req_reg.is_dir;
        new_entry.pay.idle   = '0;
    end

    // Head compare and aging
    always_comb begin
        in_range = (FW'(idx_reg) < used_reg);
        match    = cell_out[0].valid && (cell_out[0].pay.volume == req_reg.volume) &&
                   (cell_out[0].pay.dev == req_reg.dev) &&
                   (cell_out[0].pay.inode == req_reg.inode);
        sum      = {1'b0, cell_out[0].pay.idle} +
                   (cell_out[0].pay.is_dir ? ianc_pkg::DIR_AGE : ianc_pkg::FILE_AGE);
        aged     = sum[IB] ? ianc_pkg::IDLE_MAX : sum[IB-1:0];
    end

    // Insert target: first gap, else append, else most idle
    always_comb begin
        append = 1'b0;
        evict  = 1'b0;
        if (have_free_reg) begin
            target = free_reg;
        end else if (used_reg < FW'(N)) begin
            target = used_reg[SW-1:0];
            append = 1'b1;
        end else begin
            target = max_slot_reg;
            evict  = 1'b1;
        end
    end

    // Datapath next values
    always_comb begin
        proc           = cell_out[0];
        req_next       = req_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        ev_next        = ev_reg;
        have_free_next = have_free_reg;
        free_next      = free_reg;
        peak_age_next  = peak_age_reg;
        max_slot_next  = max_slot_reg;
        keep_next      = keep_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;

        if (accept) begin
            req_next.mode        = ianc_pkg::mode_t'(s_tuser);
            req_next.volume      = s_tdata[7:0];
            req_next.dev         = s_tdata[39:8];
            req_next.inode       = s_tdata[71:40];
            req_next.is_dir      = s_tdata[72];
            req_next.vol_changed = s_tdata[73];
            idx_next       = '0;
            found_next     = 1'b0;
            slot_next      = '0;
            ev_next        = 1'b0;
            have_free_next = 1'b0;
            free_next      = '0;
            peak_age_next  = '0;
            max_slot_next  = '0;
            keep_next      = '0;
            if (s_tuser == ianc_pkg::MODE_INV_ALL) begin
                used_next = '0;
            end
        end

        if (ctl.shift_en) begin
            idx_next = idx_reg + SW'(1);
            case (req_reg.mode)
                ianc_pkg::MODE_LOOKUP: begin
                    if (in_range && !req_reg.vol_changed && !found_reg && match) begin
                        proc.pay.idle = '0;
                        found_next    = 1'b1;
                        slot_next     = idx_reg;
                    end
                end
                ianc_pkg::MODE_INSERT: begin
                    if (in_range) begin
                        if (!cell_out[0].valid) begin
                            if (!have_free_reg) begin
                                have_free_next = 1'b1;
                                free_next      = idx_reg;
                            end
                        end else begin
                            proc.pay.idle = aged;
                            if (aged > peak_age_reg) begin
                                peak_age_next = aged;
                                max_slot_next = idx_reg;
                            end
                        end
                    end
                end
                ianc_pkg::MODE_INV_VOL: begin
                    if (in_range) begin
                        if (cell_out[0].valid && cell_out[0].pay.volume == req_reg.volume) begin
                            proc.valid = 1'b0;
                        end else begin
                            keep_next = FW'(idx_reg) + FW'(1);
                        end
                    end
                    if (last) begin
                        used_next = keep_next;
                    end
                end
                default: ;
            endcase
        end

        if (place_en) begin
            slot_next = target;
            ev_next   = evict;
            if (append) begin
                used_next = used_reg + FW'(1);
            end
        end

        if (resp_en) begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, 7'(used_reg), ev_reg, 6'(slot_reg), found_reg};
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ianc_pkg::ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        slot_reg      <= slot_next;
        ev_reg        <= ev_next;
        have_free_reg <= have_free_next;
        free_reg      <= free_next;
        peak_age_reg  <= peak_age_next;
        max_slot_reg  <= max_slot_next;
        keep_reg      <= keep_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/core/ianc_check.sv =====
`include "idle_aged_node_cache_macros.svh"

module ianc_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // One request in work at a time
    `IANC_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    // A stalled result holds
    `IANC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // A lookup hit never reports an eviction
    `IANC_ASSERT_SAME(a_hit_no_evict, m_tvalid, !(m_tdata[0] && m_tdata[7]))
    // Fill level stays within the directory
    `IANC_ASSERT_SAME(a_fill_range, m_tvalid, m_tdata[14:8] <= 7'd64)

endmodule

bind idle_aged_node_cache ianc_check u_ianc_check (.*);
